// ===== hw/rtl/s2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants of the sample to decimal text pipeline
// Holds field widths, the ASCII codes used in the display and the payload
// structures handed from one pipeline stage to the next.
// ----------------------------------------------------------------------------
package s2d_pkg;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int MAG_W    = 12;
   localparam int CHAR_W   = 6;
   localparam int TH_W     = 2;
   localparam int DIGIT_W  = 4;
   localparam int REM3_W   = 10;
   localparam int REM2_W   = 7;

   // Decimal weights and the largest value of one digit.
   localparam int THOUSAND  = 1000;
   localparam int HUNDRED   = 100;
   localparam int TEN       = 10;
   localparam int DIGIT_MAX = 9;

   // ASCII codes, cut to the width of a character field.
   localparam logic [CHAR_W-1:0] CH_PLUS  = 6'd43;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

   // Sign and magnitude of one sample.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } mag_type;

   // Thousands digit split off, remainder below one thousand.
   typedef struct packed {
      logic              neg;
      logic [TH_W-1:0]   th;
      logic [REM3_W-1:0] rem;
   } thou_type;

   // Hundreds digit split off, remainder below one hundred.
   typedef struct packed {
      logic               neg;
      logic [TH_W-1:0]    th;
      logic [DIGIT_W-1:0] hu;
      logic [REM2_W-1:0]  rem;
   } hund_type;

   // Five display characters of one result.
   typedef struct packed {
      logic [CHAR_W-1:0] sign_char;
      logic [CHAR_W-1:0] thousands_char;
      logic [CHAR_W-1:0] hundreds_char;
      logic [CHAR_W-1:0] tens_char;
      logic [CHAR_W-1:0] ones_char;
   } result_type;

endpackage

// ===== hw/rtl/s2d_mag.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_mag: sign and magnitude stage
// Takes the two's complement sample apart into a sign flag and a 12-bit
// magnitude of at most 2048.
// ----------------------------------------------------------------------------
module s2d_mag (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [s2d_pkg::SAMPLE_W-1:0]  in_sample,
   output logic                          out_valid,
   input  logic                          out_stall,
   output s2d_pkg::mag_type              out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic             advance;
   s2d_pkg::mag_type data_ff;
   s2d_pkg::mag_type data_in;

   // The stage moves when it is empty or its content leaves in this cycle.
   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // Negative samples are negated in twelve bits; 0x800 stays 2048.
   always_comb begin
      data_in.neg = in_sample[s2d_pkg::SAMPLE_W-1];
      if (data_in.neg) begin
         data_in.mag = (~in_sample) + 12'd1;
      end else begin
         data_in.mag = in_sample;
      end
   end

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on each transfer into the stage.
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/s2d_thou.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_thou: thousands digit stage
// Splits the thousands digit off the magnitude by compare and subtract and
// passes the remainder below one thousand on.
// ----------------------------------------------------------------------------
module s2d_thou (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  s2d_pkg::mag_type  in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output s2d_pkg::thou_type out_data
);

   localparam logic [s2d_pkg::MAG_W-1:0] ONE_K = s2d_pkg::MAG_W'(s2d_pkg::THOUSAND);
   localparam logic [s2d_pkg::MAG_W-1:0] TWO_K = s2d_pkg::MAG_W'(2 * s2d_pkg::THOUSAND);

   logic                        valid_ff;
   logic                        valid_in;
   logic                        advance;
   logic [s2d_pkg::MAG_W-1:0]   rem_full;
   s2d_pkg::thou_type           data_ff;
   s2d_pkg::thou_type           data_in;

   // The stage moves when it is empty or its content leaves in this cycle.
   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // The magnitude is at most 2048, so the digit is 0, 1 or 2.
   always_comb begin
      data_in.neg = in_data.neg;
      if (in_data.mag >= TWO_K) begin
         data_in.th = 2'd2;
         rem_full   = in_data.mag - TWO_K;
      end else if (in_data.mag >= ONE_K) begin
         data_in.th = 2'd1;
         rem_full   = in_data.mag - ONE_K;
      end else begin
         data_in.th = 2'd0;
         rem_full   = in_data.mag;
      end
      data_in.rem = rem_full[s2d_pkg::REM3_W-1:0];
   end

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on each transfer into the stage.
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/s2d_hund.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_hund: hundreds digit stage
// Finds the hundreds digit with nine parallel compares and subtracts its
// weight, leaving a remainder below one hundred.
// ----------------------------------------------------------------------------
module s2d_hund (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  s2d_pkg::thou_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output s2d_pkg::hund_type out_data
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          advance;
   logic [s2d_pkg::REM3_W-1:0]    rem_full;
   s2d_pkg::hund_type             data_ff;
   s2d_pkg::hund_type             data_in;

   // The stage moves when it is empty or its content leaves in this cycle.
   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // The digit is the number of hundreds steps that the remainder reaches.
   always_comb begin
      data_in.neg = in_data.neg;
      data_in.th  = in_data.th;
      data_in.hu  = '0;
      for (int k = 1; k <= s2d_pkg::DIGIT_MAX; k++) begin
         if (in_data.rem >= s2d_pkg::REM3_W'(k * s2d_pkg::HUNDRED)) begin
            data_in.hu = data_in.hu + 4'd1;
         end
      end
      rem_full    = in_data.rem
                  - s2d_pkg::REM3_W'(data_in.hu) * s2d_pkg::REM3_W'(s2d_pkg::HUNDRED);
      data_in.rem = rem_full[s2d_pkg::REM2_W-1:0];
   end

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on each transfer into the stage.
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/s2d_tens.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_tens: tens, ones and character stage
// Splits the last remainder into tens and ones, turns all digits into ASCII
// with leading zero blanking and holds the result in the output register.
// ----------------------------------------------------------------------------
module s2d_tens (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  s2d_pkg::hund_type   in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output s2d_pkg::result_type out_data
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          advance;
   logic [s2d_pkg::DIGIT_W-1:0]   te;
   logic [s2d_pkg::REM2_W-1:0]    ones_full;
   logic                          blank_th;
   logic                          blank_hu;
   logic                          blank_te;
   s2d_pkg::result_type           data_ff;
   s2d_pkg::result_type           data_in;

   // The stage moves when it is empty or its content leaves in this cycle.
   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // Tens digit by parallel compares, ones digit by subtraction.
   always_comb begin
      te = '0;
      for (int k = 1; k <= s2d_pkg::DIGIT_MAX; k++) begin
         if (in_data.rem >= s2d_pkg::REM2_W'(k * s2d_pkg::TEN)) begin
            te = te + 4'd1;
         end
      end
      ones_full = in_data.rem - s2d_pkg::REM2_W'(te) * s2d_pkg::REM2_W'(s2d_pkg::TEN);
   end

   // A digit is blanked only when it and every higher digit are zero.
   assign blank_th = (in_data.th == 2'd0);
   assign blank_hu = blank_th && (in_data.hu == 4'd0);
   assign blank_te = blank_hu && (te == 4'd0);

   always_comb begin
      data_in.sign_char      = in_data.neg ? s2d_pkg::CH_MINUS : s2d_pkg::CH_PLUS;
      data_in.thousands_char = blank_th ? s2d_pkg::CH_SPACE
                             : s2d_pkg::CH_ZERO + {4'd0, in_data.th};
      data_in.hundreds_char  = blank_hu ? s2d_pkg::CH_SPACE
                             : s2d_pkg::CH_ZERO + {2'd0, in_data.hu};
      data_in.tens_char      = blank_te ? s2d_pkg::CH_SPACE
                             : s2d_pkg::CH_ZERO + {2'd0, te};
      data_in.ones_char      = s2d_pkg::CH_ZERO
                             + {2'd0, ones_full[s2d_pkg::DIGIT_W-1:0]};
   end

   // Valid bit of the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result characters are loaded on each transfer into the stage.
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/signed12_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Throughput: one sample per cycle while rsp_stall is low; four register
// stages (sign and magnitude, thousands, hundreds, tens and characters) each
// hold one sample. A stall on the result side holds each full stage that has
// no empty stage after it, and reaches req_stall only when all four are full.
// Reset clears the stage valid bits only; no result is pending after it.
// ----------------------------------------------------------------------------
// signed12_to_decimal_ascii: signed 12-bit sample to five display characters
// Converts a two's complement sample into a sign and four decimal digits in
// ASCII, with leading zero digits shown as spaces.
// ----------------------------------------------------------------------------
module signed12_to_decimal_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [s2d_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [s2d_pkg::CHAR_W-1:0]    rsp_sign_char,
   output logic [s2d_pkg::CHAR_W-1:0]    rsp_thousands_char,
   output logic [s2d_pkg::CHAR_W-1:0]    rsp_hundreds_char,
   output logic [s2d_pkg::CHAR_W-1:0]    rsp_tens_char,
   output logic [s2d_pkg::CHAR_W-1:0]    rsp_ones_char
);

   logic                mag_valid;
   logic                mag_stall;
   s2d_pkg::mag_type    mag_data;
   logic                thou_valid;
   logic                thou_stall;
   s2d_pkg::thou_type   thou_data;
   logic                hund_valid;
   logic                hund_stall;
   s2d_pkg::hund_type   hund_data;
   s2d_pkg::result_type result;

   // Stage one: sign and magnitude.
   s2d_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_sample (req_sample),
      .out_valid (mag_valid),
      .out_stall (mag_stall),
      .out_data  (mag_data)
   );

   // Stage two: thousands digit.
   s2d_thou u_thou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_stall  (mag_stall),
      .in_data   (mag_data),
      .out_valid (thou_valid),
      .out_stall (thou_stall),
      .out_data  (thou_data)
   );

   // Stage three: hundreds digit.
   s2d_hund u_hund (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (thou_valid),
      .in_stall  (thou_stall),
      .in_data   (thou_data),
      .out_valid (hund_valid),
      .out_stall (hund_stall),
      .out_data  (hund_data)
   );

   // Stage four: tens, ones and the output characters.
   s2d_tens u_tens (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hund_valid),
      .in_stall  (hund_stall),
      .in_data   (hund_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (result)
   );

   assign rsp_sign_char      = result.sign_char;
   assign rsp_thousands_char = result.thousands_char;
   assign rsp_hundreds_char  = result.hundreds_char;
   assign rsp_tens_char      = result.tens_char;
   assign rsp_ones_char      = result.ones_char;

   // The input is held off only when every stage is full.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mag_valid && thou_valid && hund_valid && rsp_valid))
      else $error("input stalled while a pipeline stage is empty");

   // The sign character is always plus or minus.
   a_sign_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sign_char == s2d_pkg::CH_PLUS ||
                     rsp_sign_char == s2d_pkg::CH_MINUS))
      else $error("sign character is neither plus nor minus");

   // Below a blank thousands place a zero hundreds digit must be blank too.
   a_blanking : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_thousands_char == s2d_pkg::CH_SPACE)
         |-> (rsp_hundreds_char != s2d_pkg::CH_ZERO))
      else $error("zero hundreds digit shown after a blank thousands place");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the signed sample to decimal text block
// Walks a short table of directed samples, then 1129 random ones,
// through the valid/stall input channel with random gaps and receiver stalls.
// Every result transfer is compared field by field with the expected display,
// typed in or locally computed, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import s2d_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int ITEM_COUNT    = 1150;
   localparam int NUM_DIRECTED  = 21;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 60;
   localparam int MAX_GAP       = 4;
   localparam int PHASE_ITEMS   = 64;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      string               text;
   } directed_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_sign_char;
   logic [CHAR_W-1:0]   rsp_thousands_char;
   logic [CHAR_W-1:0]   rsp_hundreds_char;
   logic [CHAR_W-1:0]   rsp_tens_char;
   logic [CHAR_W-1:0]   rsp_ones_char;

   result_type pending_displays[$];
   int         error_count = 0;
   int         cycle_count = 0;

   // Directed samples. Rows with text carry the display typed in; empty text
   // means the row is checked against the computed display.
   directed_row_t directed_rows [NUM_DIRECTED] = '{
      '{12'h000, "+   0"},
      '{12'h7FF, "+2047"},
      '{12'h800, "-2048"},
      '{12'hFFF, "-   1"},
      '{12'h001, ""},
      '{12'd9,   ""},
      '{12'd10,  ""},
      '{12'd99,  ""},
      '{12'd100, ""},
      '{12'd105, ""},
      '{12'd999, ""},
      '{12'd1000, ""},
      '{12'd1005, ""},
      '{12'd1050, ""},
      '{12'd1999, ""},
      '{12'd3091, ""},
      '{12'd3991, ""},
      '{12'd4086, ""},
      '{12'd3996, ""},
      '{12'd3096, ""},
      '{12'h801, ""}
   };

   signed12_to_decimal_ascii u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sign_char      (rsp_sign_char),
      .rsp_thousands_char (rsp_thousands_char),
      .rsp_hundreds_char  (rsp_hundreds_char),
      .rsp_tens_char      (rsp_tens_char),
      .rsp_ones_char      (rsp_ones_char)
   );

   // Free-running clock.
   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Sign and four decimal characters of one sample, leading zeros blanked.
   function automatic result_type compute_display(input logic [SAMPLE_W-1:0] sample);
      result_type          disp;
      logic [SAMPLE_W-1:0] mag;
      int unsigned         th;
      int unsigned         hu;
      int unsigned         te;
      int unsigned         on;
      if (sample > 12'h7FF) begin
         disp.sign_char = CH_MINUS;
         mag = ~sample + 12'd1;
      end else begin
         disp.sign_char = CH_PLUS;
         mag = sample;
      end
      th = mag / THOUSAND;
      hu = (mag % THOUSAND) / HUNDRED;
      te = (mag % HUNDRED) / TEN;
      on = mag % TEN;
      disp.thousands_char = (th == 0) ? CH_SPACE : CH_ZERO + CHAR_W'(th);
      disp.hundreds_char  = (th == 0 && hu == 0) ? CH_SPACE : CH_ZERO + CHAR_W'(hu);
      disp.tens_char      = (th == 0 && hu == 0 && te == 0) ? CH_SPACE : CH_ZERO + CHAR_W'(te);
      disp.ones_char      = CH_ZERO + CHAR_W'(on);
      return disp;
   endfunction

   // Five typed characters, cut to the character width of the block.
   function automatic result_type text_to_display(input string text);
      result_type disp;
      disp.sign_char      = CHAR_W'(text[0]);
      disp.thousands_char = CHAR_W'(text[1]);
      disp.hundreds_char  = CHAR_W'(text[2]);
      disp.tens_char      = CHAR_W'(text[3]);
      disp.ones_char      = CHAR_W'(text[4]);
      return disp;
   endfunction

   // Random sample, weighted toward small magnitudes and digit boundaries.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int mag;
      int step;
      bit neg;
      neg = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         6, 7: begin
            mag = $urandom_range(0, 120);
         end
         8: begin
            mag = 2048 - $urandom_range(0, 3);
         end
         9: begin
            mag  = $urandom_range(0, 2048);
            step = ($urandom_range(1, 3) == 1) ? TEN : ($urandom_range(0, 1) ? HUNDRED : THOUSAND);
            mag  = mag - (mag % step) + $urandom_range(0, 1);
         end
         default: begin
            return SAMPLE_W'($urandom_range(0, 4095));
         end
      endcase
      if (mag > 2048) mag = 2048;
      if (!neg && mag > 2047) mag = 2047;
      return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
   endfunction

   // Offers one sample after a random gap (none when no_gaps is set) and records its display on transfer.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input result_type disp,
                              input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      pending_displays.push_back(disp);
   endtask

   task automatic check_field(input string name, input logic [CHAR_W-1:0] exp_char,
                              input logic [CHAR_W-1:0] act_char);
      if (act_char !== exp_char) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_char, act_char);
         error_count++;
      end
   endtask

   // Reset, directed table, random samples, then drain and verdict.
   initial begin
      logic [SAMPLE_W-1:0] sample;
      result_type          disp;
      bit                  no_gaps;
      int                  drain;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         disp = (directed_rows[i].text.len() != 0) ? text_to_display(directed_rows[i].text)
                                                   : compute_display(directed_rows[i].sample);
         send_sample(directed_rows[i].sample, disp, 1'b0);
      end

      no_gaps = 1'b0;
      for (int n = 0; n < ITEM_COUNT - NUM_DIRECTED; n++) begin
         if (n % PHASE_ITEMS == 0) no_gaps = ($urandom_range(0, 3) == 0);
         sample = pick_sample();
         send_sample(sample, compute_display(sample), no_gaps);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_displays.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_displays.size() != 0) begin
         $error("%0d expected results never arrived", pending_displays.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Receiver: random stalls per result, with phases of no stalls and two long hold-offs
   // that fill the pipeline and push back on the input channel.
   initial begin
      int hold;
      int taken;
      bit no_stalls;
      taken     = 0;
      no_stalls = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % PHASE_ITEMS == 0) no_stalls = ($urandom_range(0, 3) == 0);
         if (taken == 150 || taken == 600) begin
            hold = HOLD_CYCLES;
         end else begin
            hold = no_stalls ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Compares each result transfer with the oldest expected display.
   always @(posedge clock) begin
      result_type exp_disp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_displays.size() == 0) begin
            $error("result transfer with no expected display waiting");
            error_count++;
         end else begin
            exp_disp = pending_displays.pop_front();
            check_field("sign_char", exp_disp.sign_char, rsp_sign_char);
            check_field("thousands_char", exp_disp.thousands_char, rsp_thousands_char);
            check_field("hundreds_char", exp_disp.hundreds_char, rsp_hundreds_char);
            check_field("tens_char", exp_disp.tens_char, rsp_tens_char);
            check_field("ones_char", exp_disp.ones_char, rsp_ones_char);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
